// ===== sv/slvd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vibrato delay package
// Shared constants, register indexes, divider request types and the
// quarter-wave sine table generator for the vibrato delay core.
// ----------------------------------------------------------------------------
package slvd_pkg;

	localparam int SINE_N      = 256;
	localparam int SINE_BITS   = 8;
	localparam int SINE_W      = 15;
	localparam int PHASE_BITS  = 24;
	localparam int DEPTH_BITS  = 24;
	localparam int TARGET_BITS = 16;
	localparam int RAMP_BITS   = 12;
	localparam int CFG_BITS    = 24;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_STEP   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH_TARGET = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_LENGTH  = 2'd2;

	localparam logic [PHASE_BITS-1:0]  PHASE_STEP_RESET   = 24'd1902;
	localparam logic [TARGET_BITS-1:0] DEPTH_TARGET_RESET = 16'd10240;
	localparam logic [RAMP_BITS-1:0]   RAMP_LENGTH_RESET  = 12'd441;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;

	typedef struct packed {
		logic                  start;
		logic                  neg;
		logic [DEPTH_BITS-1:0] magnitude;
		logic [RAMP_BITS-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Quarter-wave table, entry k at bits [k*SINE_W +: SINE_W].
	function automatic logic [(SINE_N+1)*SINE_W-1:0] sine_rom_bits();
		logic [(SINE_N+1)*SINE_W-1:0] rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		rom = '0;
		for (int k = 0; k <= SINE_N; k++) begin
			x  = (64'(k) * HALF_PI_Q30) / SINE_N;
			x2 = (x * x) >> 30;
			t  = ONE_Q30;
			t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
			t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
			t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
			t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
			t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
			s  = (x * t) >> 30;
			s  = (s + 64'd16384) >> 15;
			if (s > 64'd32767) begin
				s = 64'd32767;
			end
			rom[k*SINE_W +: SINE_W] = s[SINE_W-1:0];
		end
		return rom;
	endfunction

endpackage
`default_nettype wire

// ===== sv/slvd_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vibrato delay sample store
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module slvd_store #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 48
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/slvd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vibrato delay ramp step divider
// Restoring divider, one quotient bit per cycle, signed result truncated
// toward zero.
// ----------------------------------------------------------------------------
module slvd_div import slvd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire div_req_t              req,
	output div_stat_t                  stat,
	output logic signed [DEPTH_BITS:0] quotient
);

	logic [DEPTH_BITS-1:0] quo_q;
	logic [RAMP_BITS-1:0]  rem_q;
	logic [RAMP_BITS-1:0]  divisor_q;
	logic                  neg_q;
	logic [4:0]            cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [RAMP_BITS:0]    trial;
	logic                  fits;

	assign trial = {rem_q, quo_q[DEPTH_BITS-1]};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DEPTH_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= req.magnitude;
			rem_q     <= '0;
			divisor_q <= req.divisor;
			neg_q     <= req.neg;
		end else if (busy_q) begin
			rem_q <= fits ? RAMP_BITS'(trial - {1'b0, divisor_q}) : trial[RAMP_BITS-1:0];
			quo_q <= {quo_q[DEPTH_BITS-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule
`default_nettype wire

// ===== sv/slvd_sine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vibrato delay sine lookup
// Maps the LFO phase through the quarter-wave table to the factor
// 32768 + sin(phase) in Q15.
// ----------------------------------------------------------------------------
module slvd_sine import slvd_pkg::*; (
	input  wire logic [PHASE_BITS-1:0] phase,
	output logic      [15:0]           factor
);

	localparam logic [(SINE_N+1)*SINE_W-1:0] SINE_ROM = sine_rom_bits();

	logic [1:0]           quad;
	logic [SINE_BITS-1:0] idx;
	logic [SINE_BITS:0]   k;
	logic [SINE_W-1:0]    mag;

	assign quad   = phase[PHASE_BITS-1 -: 2];
	assign idx    = phase[PHASE_BITS-3 -: SINE_BITS];
	assign k      = quad[0] ? (SINE_N[SINE_BITS:0] - {1'b0, idx}) : {1'b0, idx};
	assign mag    = SINE_ROM[k*SINE_W +: SINE_W];
	assign factor = quad[1] ? (16'h8000 - {1'b0, mag}) : (16'h8000 + {1'b0, mag});

endmodule
`default_nettype wire

// ===== sv/sine_lfo_vibrato_delay_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo vibrato delay core
// Sine LFO modulated fractional delay line with linear interpolation and a
// linear depth ramp. One multiplier is shared by the delay and both lerps.
// ----------------------------------------------------------------------------
// Usage:
// A stereo request enters on sample_valid/sample_stall and is taken when
// valid is high and stall is low. Its result leaves on
// result_valid/result_stall from an output register loaded at write-back.
// The sequencer runs one request at a time through eight steps (sine
// lookup, delay multiply, delay decode, two store reads, two lerp
// multiplies, write-back) and takes no new request until the current one
// leaves write-back; the shared multiplier and the single store read port
// call for this. While the receiver stalls, the finished result holds and the next
// request is still taken; its write-back waits until the register frees.
// Configuration writes use cfg_valid/cfg_ready. A new depth target with a
// nonzero ramp length starts a step division, during which both cfg_ready
// and sample taking are held off.
// Reset clears the stores logically through a fill count, so the core is
// ready as soon as reset is released, with registers at their defaults.
// ----------------------------------------------------------------------------
module sine_lfo_vibrato_delay_core import slvd_pkg::*; #(
	parameter int STORE_DEPTH = 512,
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	output logic                               sample_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] left_sample,
	input  wire logic signed [SAMPLE_BITS-1:0] right_sample,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic signed [SAMPLE_BITS-1:0]      left_out,
	output logic signed [SAMPLE_BITS-1:0]      right_out,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  wire logic [CFG_BITS-1:0]           cfg_data
);

	localparam int SB = SAMPLE_BITS;
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int FW = AW + 1;
	localparam int DW = AW + 9;
	localparam int MA = (SB + 1 > DEPTH_BITS + 1) ? SB + 1 : DEPTH_BITS + 1;
	localparam int MB = 18;
	localparam int PW = MA + MB;
	localparam logic [DW-1:0] DLY_MAX = DW'((STORE_DEPTH - 1) * 256);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_DLY   = 3'd2;
	localparam logic [2:0] ST_RDA   = 3'd3;
	localparam logic [2:0] ST_RDB   = 3'd4;
	localparam logic [2:0] ST_MUL_L = 3'd5;
	localparam logic [2:0] ST_MUL_R = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0] state_q;

	logic [PHASE_BITS-1:0]  phase_step_q;
	logic [TARGET_BITS-1:0] depth_target_q;
	logic [RAMP_BITS-1:0]   ramp_length_q;
	logic [DEPTH_BITS-1:0]  depth_now_q;
	logic signed [DEPTH_BITS:0] depth_step_q;
	logic [RAMP_BITS-1:0]   ramp_left_q;
	logic [PHASE_BITS-1:0]  lfo_phase_q;
	logic [AW-1:0]          wr_idx_q;
	logic [FW-1:0]          fill_q;
	logic                   result_valid_q;

	logic [2*SB-1:0]        samp_q;
	logic [15:0]            factor_q;
	logic signed [PW-1:0]   prod_q;
	logic [AW-1:0]          d_q;
	logic [7:0]             f_q;
	logic [2*SB-1:0]        a_q;
	logic [2*SB-1:0]        b_q;
	logic [SB-1:0]          left_res_q;
	logic [SB-1:0]          left_out_q;
	logic [SB-1:0]          right_out_q;

	logic                   sample_fire;
	logic                   cfg_fire;
	logic                   out_free;
	logic                   finish;
	logic [TARGET_BITS-1:0] tgt_new;
	logic signed [DEPTH_BITS:0] tdiff;
	div_req_t               div_req;
	div_stat_t              div_stat;
	logic signed [DEPTH_BITS:0] div_quo;
	logic [15:0]            sine_factor;

	logic [DW-1:0]          dly_sum;
	logic [FW-1:0]          age;
	logic signed [FW-1:0]   addr_diff;
	logic [AW-1:0]          raddr;
	logic                   re;
	logic [2*SB-1:0]        rdata;
	logic                   a_ok;
	logic                   b_ok;
	logic [2*SB-1:0]        b_now;
	logic signed [SB:0]     diff_s;
	logic signed [MA-1:0]   mul_a;
	logic signed [MB-1:0]   mul_b;
	logic signed [PW-1:0]   mul_p;
	logic [SB-1:0]          right_res;

	assign sample_fire  = sample_valid && !sample_stall;
	assign cfg_fire     = cfg_valid && cfg_ready;
	assign out_free     = !result_valid_q || !result_stall;
	assign finish       = (state_q == ST_DONE) && out_free;
	assign sample_stall = (state_q != ST_IDLE) || div_stat.busy || div_stat.done;
	assign cfg_ready    = !(div_stat.busy || div_stat.done);

	assign tgt_new = cfg_data[TARGET_BITS-1:0];
	assign tdiff   = $signed({1'b0, tgt_new, 8'h00}) - $signed({1'b0, depth_now_q});

	assign div_req.start = cfg_fire && (cfg_index == REG_DEPTH_TARGET)
	                       && (tgt_new != depth_target_q) && (ramp_length_q != '0);
	assign div_req.neg       = tdiff[DEPTH_BITS];
	assign div_req.magnitude = tdiff[DEPTH_BITS] ? DEPTH_BITS'(-tdiff) : tdiff[DEPTH_BITS-1:0];
	assign div_req.divisor   = ramp_length_q;

	slvd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	slvd_sine u_sine (
		.phase  (lfo_phase_q),
		.factor (sine_factor)
	);

	assign dly_sum = DW'(prod_q[DEPTH_BITS+15:23]) + DW'(256);

	assign age       = (state_q == ST_RDB) ? (FW'(d_q) + FW'(1)) : FW'(d_q);
	assign addr_diff = $signed({1'b0, wr_idx_q}) - $signed(age);
	assign raddr     = addr_diff[FW-1] ? AW'(addr_diff + FW'(STORE_DEPTH)) : addr_diff[AW-1:0];
	assign re        = (state_q == ST_RDA) || (state_q == ST_RDB);

	slvd_store #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (2 * SB)
	) u_store (
		.clk   (clk),
		.we    (finish),
		.waddr (wr_idx_q),
		.wdata (samp_q),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign a_ok  = FW'(d_q) <= fill_q;
	assign b_ok  = FW'(d_q) < fill_q;
	assign b_now = b_ok ? rdata : '0;

	always_comb begin
		if (state_q == ST_MUL_L) begin
			diff_s = $signed({b_now[2*SB-1], b_now[2*SB-1:SB]})
			       - $signed({a_q[2*SB-1], a_q[2*SB-1:SB]});
		end else begin
			diff_s = $signed({b_q[SB-1], b_q[SB-1:0]}) - $signed({a_q[SB-1], a_q[SB-1:0]});
		end
		if (state_q == ST_MUL) begin
			mul_a = MA'({1'b0, depth_now_q});
			mul_b = MB'({1'b0, factor_q});
		end else begin
			mul_a = MA'(diff_s);
			mul_b = MB'({1'b0, f_q});
		end
	end

	assign mul_p     = PW'(mul_a) * PW'(mul_b);
	assign right_res = a_q[SB-1:0] + prod_q[SB+7:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			phase_step_q   <= PHASE_STEP_RESET;
			depth_target_q <= DEPTH_TARGET_RESET;
			ramp_length_q  <= RAMP_LENGTH_RESET;
			depth_now_q    <= {DEPTH_TARGET_RESET, 8'h00};
			depth_step_q   <= '0;
			ramp_left_q    <= '0;
			lfo_phase_q    <= '0;
			wr_idx_q       <= '0;
			fill_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				unique case (cfg_index)
					REG_PHASE_STEP: begin
						phase_step_q <= cfg_data[PHASE_BITS-1:0];
					end
					REG_DEPTH_TARGET: begin
						if (tgt_new != depth_target_q) begin
							depth_target_q <= tgt_new;
							if (ramp_length_q == '0) begin
								depth_now_q  <= {tgt_new, 8'h00};
								ramp_left_q  <= '0;
								depth_step_q <= '0;
							end else begin
								ramp_left_q <= ramp_length_q;
							end
						end
					end
					REG_RAMP_LENGTH: begin
						ramp_length_q <= cfg_data[RAMP_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			if (div_stat.done) begin
				depth_step_q <= div_quo;
			end
			if (finish) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sample_fire) begin
						state_q <= ST_MUL;
						if (ramp_left_q != '0) begin
							ramp_left_q <= ramp_left_q - RAMP_BITS'(1);
							if (ramp_left_q != RAMP_BITS'(1)) begin
								depth_now_q <= depth_now_q + depth_step_q[DEPTH_BITS-1:0];
							end else begin
								depth_now_q <= {depth_target_q, 8'h00};
							end
						end
					end
				end
				ST_MUL:   state_q <= ST_DLY;
				ST_DLY:   state_q <= ST_RDA;
				ST_RDA:   state_q <= ST_RDB;
				ST_RDB:   state_q <= ST_MUL_L;
				ST_MUL_L: state_q <= ST_MUL_R;
				ST_MUL_R: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						wr_idx_q    <= (wr_idx_q == AW'(STORE_DEPTH - 1)) ? '0
						               : wr_idx_q + AW'(1);
						lfo_phase_q <= lfo_phase_q + phase_step_q;
						if (fill_q != FW'(STORE_DEPTH)) begin
							fill_q <= fill_q + FW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sample_fire) begin
			samp_q   <= {left_sample, right_sample};
			factor_q <= sine_factor;
		end
		if ((state_q == ST_MUL) || (state_q == ST_MUL_L) || (state_q == ST_MUL_R)) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_DLY) begin
			if (dly_sum > DLY_MAX) begin
				d_q <= AW'(STORE_DEPTH - 1);
				f_q <= '0;
			end else begin
				d_q <= dly_sum[AW+7:8];
				f_q <= dly_sum[7:0];
			end
		end
		if (state_q == ST_RDB) begin
			a_q <= a_ok ? rdata : '0;
		end
		if (state_q == ST_MUL_L) begin
			b_q <= b_now;
		end
		if (state_q == ST_MUL_R) begin
			left_res_q <= a_q[2*SB-1:SB] + prod_q[SB+7:8];
		end
		if (finish) begin
			left_out_q  <= left_res_q;
			right_out_q <= right_res;
		end
	end

	assign result_valid = result_valid_q;
	assign left_out     = left_out_q;
	assign right_out    = right_out_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_fire |=> sample_stall)
		else $error("request taken but core did not go busy");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside write-back step");

	a_div_blocks_samples: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready |-> sample_stall)
		else $error("request window open during step division");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (fill_q <= FW'(STORE_DEPTH)) && (state_q == ST_IDLE))
		else $error("fill count or sequencer wrong after write-back");

endmodule
`default_nettype wire

// ===== tb/tb_sine_lfo_vibrato_delay_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo vibrato delay core testbench
// Drives stereo requests and register writes into the core and checks each
// delayed stereo result against a cycle-free model of the sine LFO, the depth
// ramp and the interpolating delay lines kept inside this bench, or, for a
// checked directed row, against its expected values. A short table of directed
// requests comes first, then phases of random samples with random register
// settings between them, under random source gaps and sink stalls but in three phases run with neither.
// ----------------------------------------------------------------------------
module tb_sine_lfo_vibrato_delay_core;
	import slvd_pkg::*;

	localparam int SW = 24;
	localparam int STORE = 512;
	localparam int MAX_DELAY = (STORE - 1) * 256;
	localparam int RANDOM_FRAMES = 1090;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam logic [23:0] STEP_AT_RESET = 24'd1902;
	localparam logic [15:0] GOAL_AT_RESET = 16'd10240;
	localparam logic [11:0] RAMP_AT_RESET = 12'd441;
	localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
	localparam logic [63:0] UNIT_Q30 = 64'd1073741824;

	typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [CFG_IDX_BITS-1:0] idx;
		logic [SW-1:0]           a;
		logic [SW-1:0]           b;
		logic                    typed;
		logic [SW-1:0]           exp_l;
		logic [SW-1:0]           exp_r;
	} row_t;

	typedef struct packed {
		logic signed [SW-1:0] left;
		logic signed [SW-1:0] right;
	} frame_t;

	logic                    clk;
	logic                    arst_n;
	logic                    sample_valid;
	logic                    sample_stall;
	logic signed [SW-1:0]    left_sample;
	logic signed [SW-1:0]    right_sample;
	logic                    result_valid;
	logic                    result_stall;
	logic signed [SW-1:0]    left_out;
	logic signed [SW-1:0]    right_out;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]     cfg_data;

	int gap_pct = 7;
	int stall_pct = 7;
	int mismatches = 0;
	frame_t due_frames[$];

	int                   sine_q [0:256];
	logic signed [SW-1:0] left_line [STORE];
	logic signed [SW-1:0] right_line [STORE];
	int                   wr_ptr;
	logic [23:0]          lfo_acc;
	logic [23:0]          lfo_step;
	logic [15:0]          depth_goal;
	logic [11:0]          ramp_len;
	logic [23:0]          depth_cur;
	int                   depth_inc;
	int                   ramp_count;

	sine_lfo_vibrato_delay_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.left_sample(left_sample),
		.right_sample(right_sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.left_out(left_out),
		.right_out(right_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_sine_lfo_vibrato_delay_core NOT OK");
		$finish;
	end

	function automatic int quarter_wave(int k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		int          dv [5];
		dv = '{110, 72, 42, 20, 6};
		x = (64'(k) * QUARTER_TURN_Q30) / 64'd256;
		x2 = (x * x) >> 30;
		t = UNIT_Q30;
		for (int j = 0; j < 5; j++) begin
			t = UNIT_Q30 - (((x2 * t) >> 30) / 64'(dv[j]));
		end
		s = ((x * t) >> 30);
		s = (s + 64'd16384) >> 15;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		return int'(s);
	endfunction

	function automatic logic signed [SW-1:0] lerp(longint a, longint b, int f);
		longint p;
		p = (b - a) * longint'(f);
		return SW'(a + (p >>> 8));
	endfunction

	function automatic void reg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
		case (idx)
			REG_PHASE_STEP: begin
				lfo_step = data[23:0];
			end
			REG_DEPTH_TARGET: begin
				if (data[15:0] != depth_goal) begin
					depth_goal = data[15:0];
					if (ramp_len == 12'd0) begin
						depth_cur = {depth_goal, 8'd0};
						ramp_count = 0;
						depth_inc = 0;
					end else begin
						ramp_count = int'(ramp_len);
						depth_inc = int'((longint'({depth_goal, 8'd0}) - longint'(depth_cur))
							/ longint'(ramp_len));
					end
				end
			end
			REG_RAMP_LENGTH: begin
				ramp_len = data[11:0];
			end
			default: begin
			end
		endcase
	endfunction

	// Advances the LFO, ramp and delay lines by one stereo frame.
	function automatic frame_t vibrato_step(logic [SW-1:0] l, logic [SW-1:0] r);
		logic [1:0]  quad;
		int          idx;
		int          s;
		logic [63:0] dly;
		int          d;
		int          f;
		int          ia;
		int          ib;
		frame_t      o;
		if (ramp_count > 0) begin
			ramp_count--;
			if (ramp_count > 0) begin
				depth_cur = 24'(longint'(depth_cur) + longint'(depth_inc));
			end else begin
				depth_cur = {depth_goal, 8'd0};
			end
		end
		quad = lfo_acc[23:22];
		idx = int'(lfo_acc[21:14]);
		s = quad[0] ? sine_q[256 - idx] : sine_q[idx];
		if (quad[1]) begin
			s = -s;
		end
		dly = 64'd256 + ((64'(depth_cur) * 64'(32768 + s)) >> 23);
		if (dly > 64'(MAX_DELAY)) begin
			dly = 64'(MAX_DELAY);
		end
		d = int'(dly >> 8);
		f = int'(dly & 64'd255);
		ia = (wr_ptr + STORE - d) % STORE;
		ib = (wr_ptr + STORE - d - 1) % STORE;
		o.left = lerp(longint'(left_line[ia]), longint'(left_line[ib]), f);
		o.right = lerp(longint'(right_line[ia]), longint'(right_line[ib]), f);
		left_line[wr_ptr] = l;
		right_line[wr_ptr] = r;
		wr_ptr = (wr_ptr + 1) % STORE;
		lfo_acc = lfo_acc + lfo_step;
		return o;
	endfunction

	function automatic row_t cfg_row(logic [CFG_IDX_BITS-1:0] idx, logic [SW-1:0] data);
		row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.a = data;
		return r;
	endfunction

	function automatic row_t smp_row(logic [SW-1:0] l, logic [SW-1:0] r);
		row_t w;
		w = '0;
		w.kind = ROW_SAMPLE;
		w.a = l;
		w.b = r;
		return w;
	endfunction

	function automatic row_t chk_row(logic [SW-1:0] l, logic [SW-1:0] r,
		logic [SW-1:0] el, logic [SW-1:0] er);
		row_t w;
		w = smp_row(l, r);
		w.typed = 1'b1;
		w.exp_l = el;
		w.exp_r = er;
		return w;
	endfunction

	function automatic logic [SW-1:0] pick_sample();
		case ($urandom_range(15))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			default: return SW'($urandom);
		endcase
	endfunction

	task automatic send_frame(logic [SW-1:0] l, logic [SW-1:0] r, logic typed,
		logic [SW-1:0] el, logic [SW-1:0] er);
		frame_t f;
		while ($urandom_range(99) < gap_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		left_sample <= l;
		right_sample <= r;
		@(posedge clk);
		while (sample_stall) begin
			@(posedge clk);
		end
		f = vibrato_step(l, r);
		if (typed) begin
			f.left = el;
			f.right = er;
		end
		due_frames.insert(due_frames.size(), f);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		reg_write(idx, data);
	endtask

	initial begin
		frame_t f;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) begin
				if (due_frames.size() == 0) begin
					$error("result: none pending, got left_out %0d right_out %0d",
						left_out, right_out);
					mismatches++;
				end else begin
					f = due_frames.pop_front();
					if (left_out !== f.left) begin
						$error("left_out: expected %0d, got %0d", f.left, left_out);
						mismatches++;
					end
					if (right_out !== f.right) begin
						$error("right_out: expected %0d, got %0d", f.right, right_out);
						mismatches++;
					end
				end
			end
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		row_t                    plan[$];
		row_t                    row;
		int                      total;
		int                      ph;
		int                      n;
		logic [CFG_IDX_BITS-1:0] idx;
		logic [CFG_BITS-1:0]     data;

		for (int k = 0; k <= 256; k++) begin
			sine_q[k] = quarter_wave(k);
		end
		for (int k = 0; k < STORE; k++) begin
			left_line[k] = '0;
			right_line[k] = '0;
		end
		wr_ptr = 0;
		lfo_acc = '0;
		lfo_step = STEP_AT_RESET;
		depth_goal = GOAL_AT_RESET;
		ramp_len = RAMP_AT_RESET;
		depth_cur = {GOAL_AT_RESET, 8'd0};
		depth_inc = 0;
		ramp_count = 0;

		arst_n = 1'b0;
		sample_valid = 1'b0;
		left_sample = '0;
		right_sample = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;

		// The stores start cleared, so the first outputs are silent. With zero
		// depth the delay is exactly one sample and each output repeats the
		// previous input.
		plan = '{
			chk_row(24'h7FFFFF, 24'h800000, 24'h000000, 24'h000000),
			chk_row(24'h800000, 24'h7FFFFF, 24'h000000, 24'h000000),
			chk_row(24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000),
			chk_row(24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000),
			chk_row(24'h555555, 24'hAAAAAA, 24'h000000, 24'h000000),
			cfg_row(REG_RAMP_LENGTH, 24'd0),
			cfg_row(REG_DEPTH_TARGET, 24'd0),
			chk_row(24'd123, -24'sd456, 24'h555555, 24'hAAAAAA),
			chk_row(24'h7FFFFF, 24'h800000, 24'd123, -24'sd456),
			cfg_row(REG_DEPTH_TARGET, 24'd0),
			chk_row(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000),
			cfg_row(REG_UNUSED, 24'hFFFFFF),
			chk_row(24'h000000, 24'h000000, 24'h800000, 24'h7FFFFF),
			cfg_row(REG_PHASE_STEP, 24'h400000),
			cfg_row(REG_DEPTH_TARGET, 24'hFFFFFF),
			smp_row(24'd1000, -24'sd1000),
			smp_row(-24'sd77, 24'd77),
			smp_row(24'h7FFFFF, 24'd1),
			smp_row(-24'sd2, 24'h800000),
			cfg_row(REG_RAMP_LENGTH, 24'd1),
			cfg_row(REG_DEPTH_TARGET, 24'd51200),
			smp_row(24'h123456, 24'hEDCBA9),
			smp_row(24'hF0F0F0, 24'h0F0F0F),
			cfg_row(REG_PHASE_STEP, 24'hFFFFFF),
			cfg_row(REG_RAMP_LENGTH, 24'd4095),
			cfg_row(REG_DEPTH_TARGET, 24'd256),
			smp_row(24'h3C3C3C, 24'hC3C3C3),
			smp_row(24'h000001, 24'hFFFFFE),
			cfg_row(REG_PHASE_STEP, 24'd0),
			smp_row(24'h400000, 24'hBFFFFF),
			smp_row(24'h7FFFFE, 24'h800001)
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_CFG) begin
				sample_valid <= 1'b0;
				while (due_frames.size() != 0) begin
					@(posedge clk);
				end
				write_reg(row.idx, row.a);
			end else begin
				cfg_valid <= 1'b0;
				send_frame(row.a, row.b, row.typed, row.exp_l, row.exp_r);
			end
		end

		total = 0;
		ph = 0;
		while (total < RANDOM_FRAMES) begin
			sample_valid <= 1'b0;
			gap_pct = (ph >= 3 && ph <= 5) ? 0 : 7;
			stall_pct = gap_pct;
			while (due_frames.size() != 0) begin
				@(posedge clk);
			end
			n = $urandom_range(1, 4);
			for (int w = 0; w < n; w++) begin
				idx = CFG_IDX_BITS'($urandom_range(3));
				data = CFG_BITS'($urandom);
				case (idx)
					REG_PHASE_STEP: begin
						case ($urandom_range(5))
							0: data = '0;
							1: data = 24'hFFFFFF;
							2, 3: data = CFG_BITS'($urandom_range(1, 60000));
							default: begin
							end
						endcase
					end
					REG_DEPTH_TARGET: begin
						data[23:16] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'd0;
						case ($urandom_range(7))
							0: data[15:0] = 16'd0;
							1: data[15:0] = 16'd51200;
							2: data[15:0] = 16'hFFFF;
							3: data[15:0] = depth_goal;
							default: data[15:0] = 16'($urandom_range(51200));
						endcase
					end
					REG_RAMP_LENGTH: begin
						case ($urandom_range(7))
							0: data = '0;
							1: data = 24'd1;
							2: data = 24'd4095;
							default: data = CFG_BITS'($urandom_range(2, 200));
						endcase
					end
					default: begin
					end
				endcase
				write_reg(idx, data);
			end
			cfg_valid <= 1'b0;
			n = $urandom_range(60, 130);
			for (int j = 0; j < n; j++) begin
				send_frame(pick_sample(), pick_sample(), 1'b0, '0, '0);
			end
			total += n;
			ph++;
		end

		sample_valid <= 1'b0;
		while (due_frames.size() != 0) begin
			@(posedge clk);
		end
		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_sine_lfo_vibrato_delay_core OK");
		end else begin
			$display("tb_sine_lfo_vibrato_delay_core NOT OK");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/slvd_pkg.sv
sv/slvd_store.sv
sv/slvd_div.sv
sv/slvd_sine.sv
sv/sine_lfo_vibrato_delay_core.sv
tb/tb_sine_lfo_vibrato_delay_core.sv
